// ===== sv/jsu_pkg.sv =====
package jsu_pkg;

	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_ESC,
		MODE_HEX
	} mode_t;

	// character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;

	// utf-8 lead and continuation marks
	localparam logic [7:0] UTF_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF_CONT  = 8'h80;

	// command queue between front and back
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
	localparam int QUEUE_CW    = QUEUE_AW + 1;

	// one command: up to three output bytes for one input byte
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            has_byte;
		logic            string_done;
		logic            bad_escape;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ===== sv/jsu_front.sv =====
module jsu_front import jsu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  logic   [7:0] in_byte,
	output logic   push,
	output cmd_t   cmd
);

	mode_t       mode_q, mode_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [11:0] acc_q, acc_d;
	logic        produce;
	logic [4:0]  hex_v;
	logic [15:0] cp;

	// hex digit value, bit 4 set when not a hex digit
	always_comb begin
		hex_v = 5'h10;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_v = {1'b0, in_byte[3:0]};
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
			(in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			hex_v = {1'b0, in_byte[3:0] + 4'd9};
		end
	end

	assign cp = {acc_q, hex_v[3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			hex_cnt_q <= '0;
			acc_q     <= '0;
		end else if (accept) begin
			mode_q    <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			acc_q     <= acc_d;
		end
	end

	always_comb begin
		mode_d           = MODE_PLAIN;
		hex_cnt_d        = '0;
		acc_d            = '0;
		produce          = 1'b1;
		cmd.bytes        = '0;
		cmd.last_idx     = 2'd0;
		cmd.has_byte     = 1'b1;
		cmd.string_done  = 1'b0;
		cmd.bad_escape   = 1'b0;
		case (mode_q)
			MODE_ESC: begin
				case (in_byte)
					CH_BSLASH, CH_SLASH, CH_QUOTE: cmd.bytes[0] = in_byte;
					CH_B: cmd.bytes[0] = CH_BS;
					CH_F: cmd.bytes[0] = CH_FF;
					CH_N: cmd.bytes[0] = CH_LF;
					CH_R: cmd.bytes[0] = CH_CR;
					CH_T: cmd.bytes[0] = CH_TAB;
					CH_U: begin
						mode_d  = MODE_HEX;
						produce = 1'b0;
					end
					default: begin
						cmd.has_byte   = 1'b0;
						cmd.bad_escape = 1'b1;
					end
				endcase
			end
			MODE_HEX: begin
				if (hex_v[4]) begin
					cmd.has_byte   = 1'b0;
					cmd.bad_escape = 1'b1;
				end else if (hex_cnt_q != 2'd3) begin
					mode_d    = MODE_HEX;
					hex_cnt_d = hex_cnt_q + 2'd1;
					acc_d     = cp[11:0];
					produce   = 1'b0;
				end else if (cp[15:7] == '0) begin
					cmd.bytes[0] = cp[7:0];
				end else if (cp[15:11] == '0) begin
					cmd.bytes[0] = UTF_LEAD2 | {3'b000, cp[10:6]};
					cmd.bytes[1] = UTF_CONT | {2'b00, cp[5:0]};
					cmd.last_idx = 2'd1;
				end else begin
					cmd.bytes[0] = UTF_LEAD3 | {4'b0000, cp[15:12]};
					cmd.bytes[1] = UTF_CONT | {2'b00, cp[11:6]};
					cmd.bytes[2] = UTF_CONT | {2'b00, cp[5:0]};
					cmd.last_idx = 2'd2;
				end
			end
			default: begin
				if (in_byte == CH_BSLASH) begin
					mode_d  = MODE_ESC;
					produce = 1'b0;
				end else if (in_byte == CH_QUOTE) begin
					cmd.has_byte    = 1'b0;
					cmd.string_done = 1'b1;
				end else begin
					cmd.bytes[0] = in_byte;
				end
			end
		endcase
	end

	assign push = accept && produce;

endmodule

// ===== sv/jsu_queue.sv =====
module jsu_queue import jsu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmd_t          wr_cmd,
	input  logic          pop,
	output cmd_t          rd_cmd,
	output queue_status_t status
);

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	assign status.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/jsu_back.sv =====
module jsu_back import jsu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          head,
	input  queue_status_t status,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          has_byte,
	output logic          run_last,
	output logic          string_done,
	output logic          bad_escape
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       has_q, last_q, done_q, bad_q;
	logic       load, take, at_last;
	logic [7:0] sel_byte;

	assign load    = !out_valid_q || !out_stall;
	assign take    = load && !status.empty;
	assign at_last = (idx_q == head.last_idx);
	assign pop     = take && at_last;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.bytes[0];
			2'd1:    sel_byte = head.bytes[1];
			default: sel_byte = head.bytes[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !status.empty;
			end
			if (take) begin
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= sel_byte;
			has_q  <= head.has_byte;
			last_q <= at_last;
			done_q <= head.string_done;
			bad_q  <= head.bad_escape;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign has_byte    = has_q;
	assign run_last    = last_q;
	assign string_done = done_q;
	assign bad_escape  = bad_q;

endmodule

// ===== sv/json_string_unescape.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | in_byte
// out     | output    | out_valid / out_stall| out_byte has_byte run_last string_done bad_escape
//
// one input byte is taken per cycle while the four-entry command queue has room
// each result leaves through the output register at one per cycle unless out_stall holds it,
// so a \u escape that expands to three utf-8 bytes gives three results, one per utf-8 byte
// a result is written into the command queue on its input transfer and then loaded into the output register
// arst_n clears decode mode, queue pointers and the output valid
// in_stall rises only when the queue is full; out_stall holds the output register while out_valid is high
module json_string_unescape import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       run_last,
	output logic       string_done,
	output logic       bad_escape
);

	logic          accept, push, pop;
	cmd_t          wr_cmd, head;
	queue_status_t status;

	assign in_stall = status.full;
	assign accept   = in_valid && !in_stall;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.in_byte(in_byte),
		.push   (push),
		.cmd    (wr_cmd)
	);

	jsu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (head),
		.status (status)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.status     (status),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.run_last   (run_last),
		.string_done(string_done),
		.bad_escape (bad_escape)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full && !pop))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty))
		else $error("command queue underflow");

	a_flag_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (string_done || bad_escape)) |-> (!has_byte && run_last))
		else $error("status result carries a byte or is not last");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(string_done && bad_escape))
		else $error("done and bad escape together");

endmodule
